### src/ddo_pkg.sv
`timescale 1ns / 1ps
// Odometry package: fixed-point constants and the CORDIC arctangent table.
// No dependencies.
package ddo_pkg;

    localparam int unsigned CordicMax      = 32;
    localparam int unsigned CordicIterDflt = 24;

    localparam logic signed [33:0] Q28Pi     = 34'sd843314857;
    localparam logic signed [33:0] Q28HalfPi = 34'sd421657428;
    localparam logic signed [33:0] Q28TwoPi  = 34'sd1686629713;
    localparam logic signed [33:0] CordicK   = 34'sd652032874;
    localparam logic [9:0]         StepDiv   = 10'd1000;

    localparam logic [23:0] TrackReset  = 24'd9830;
    localparam logic [23:0] OffsetReset = 24'd0;

    localparam logic ReqUpdate = 1'b0;
    localparam logic ReqClear  = 1'b1;

    localparam logic CfgTrack  = 1'b0;
    localparam logic CfgOffset = 1'b1;

    typedef logic signed [47:0] t_pos;

    function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:  v = 34'sd843314856;
            5'd1:  v = 34'sd497837829;
            5'd2:  v = 34'sd263043836;
            5'd3:  v = 34'sd133525158;
            5'd4:  v = 34'sd67021686;
            5'd5:  v = 34'sd33543515;
            5'd6:  v = 34'sd16775850;
            5'd7:  v = 34'sd8388437;
            5'd8:  v = 34'sd4194282;
            5'd9:  v = 34'sd2097149;
            5'd10: v = 34'sd1048575;
            5'd11: v = 34'sd524287;
            5'd12: v = 34'sd262143;
            5'd13: v = 34'sd131071;
            5'd14: v = 34'sd65535;
            5'd15: v = 34'sd32767;
            5'd16: v = 34'sd16383;
            5'd17: v = 34'sd8191;
            5'd18: v = 34'sd4095;
            5'd19: v = 34'sd2047;
            5'd20: v = 34'sd1023;
            5'd21: v = 34'sd511;
            5'd22: v = 34'sd255;
            5'd23: v = 34'sd127;
            5'd24: v = 34'sd63;
            5'd25: v = 34'sd31;
            5'd26: v = 34'sd15;
            5'd27: v = 34'sd7;
            5'd28: v = 34'sd3;
            5'd29: v = 34'sd1;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

### src/differential_drive_odometry.sv
`timescale 1ns / 1ps
// Differential-drive odometry top level: serial divider, CORDIC, pose update.
// Depends on ddo_pkg.
//
// One request at a time. An update request first goes through the bit-serial
// heading-step divider. It then runs two sine/cosine passes. Each pass has a
// heading step, modulo-2pi reduction, a fold step, CORDIC_ITERATIONS rotation
// steps (capped at CordicMax) and shared-multiplier scaling and summing; the
// result is then loaded into the output register. A clear request goes
// straight to that load. The result sits in an output register, so the next
// request is taken while it waits.
module differential_drive_odometry
    import ddo_pkg::*;
#(
    parameter int unsigned CORDIC_ITERATIONS = CordicIterDflt
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_addr,
    input  logic [23:0]  i_cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // left_distance, right_distance, centre_distance
    input  logic         s_tuser,   // req_type
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [255:0] m_tdata    // pose_x, pose_y, heading, heading_step, sensor_x, sensor_y
);

    localparam logic [3:0] S_IDLE = 4'd0, S_DIV = 4'd1, S_RED = 4'd2, S_FOLD = 4'd3,
                           S_ROT = 4'd4, S_MUL = 4'd5, S_ADD = 4'd6, S_HEAD = 4'd7,
                           S_DONE = 4'd8;
    localparam int unsigned IterCap = (CORDIC_ITERATIONS > CordicMax) ?
                                      CordicMax : CORDIC_ITERATIONS;
    localparam logic [5:0] IterLast = 6'(IterCap - 1);

    logic [3:0]  r_state;
    logic [23:0] r_track, r_offset;
    t_pos        r_pos_x, r_pos_y, r_sx, r_sy;
    logic signed [31:0] r_heading, r_step, r_dist;
    logic [33:0] r_den, r_rem;
    logic [60:0] r_num;
    logic        r_neg, r_phase, r_sel;
    logic [5:0]  r_cnt;
    logic signed [33:0] r_ang, r_x, r_y, r_z, r_sin;
    logic [33:0] r_mag;
    logic signed [65:0] r_prod;

    // divider step
    logic [34:0] n_trial;
    logic        n_qbit;
    assign n_trial = {r_rem, r_num[60]};
    assign n_qbit  = n_trial >= {1'b0, r_den};

    // step saturation
    logic signed [31:0] n_step;
    always_comb begin
        if (r_neg) begin
            n_step = (|r_num[60:31]) ? 32'sh8000_0000 : -$signed(r_num[31:0]);
        end else begin
            n_step = (|r_num[60:31]) ? 32'sh7FFF_FFFF : $signed(r_num[31:0]);
        end
    end

    // fold into [-pi/2, pi/2]
    logic signed [33:0] n_r, n_r2, n_fold;
    logic               n_flip;
    always_comb begin
        n_r = r_ang[33] ? -$signed(r_mag) : $signed(r_mag);
        n_r2 = n_r;
        if (n_r >= Q28Pi) n_r2 = n_r - Q28TwoPi;
        else if (n_r < -Q28Pi) n_r2 = n_r + Q28TwoPi;
        n_flip = 1'b0;
        n_fold = n_r2;
        if (n_r2 > Q28HalfPi) begin
            n_fold = Q28Pi - n_r2;
            n_flip = 1'b1;
        end else if (n_r2 < -Q28HalfPi) begin
            n_fold = -Q28Pi - n_r2;
            n_flip = 1'b1;
        end
    end

    // scaled sum with 48-bit saturation
    logic signed [35:0] n_scaled;
    logic signed [49:0] n_sum;
    t_pos               n_sat;
    logic signed [32:0] n_hsum;
    assign n_scaled = 36'((r_prod + 66'sd536870912) >>> 30);
    assign n_sum = 50'(r_phase ? (r_sel ? r_pos_y : r_pos_x) : (r_sel ? r_pos_y : r_pos_x))
                   + 50'(n_scaled);
    always_comb begin
        if (n_sum > 50'sh0_7FFF_FFFF_FFFF) n_sat = 48'sh7FFF_FFFF_FFFF;
        else if (n_sum < -50'sh0_8000_0000_0000) n_sat = 48'sh8000_0000_0000;
        else n_sat = n_sum[47:0];
    end
    assign n_hsum = 33'(r_heading) + 33'(r_step);

    logic signed [32:0] n_diff;
    logic [32:0]        n_adiff;
    logic [23:0]        n_tw;
    assign n_diff  = 33'($signed(s_tdata[63:32])) - 33'($signed(s_tdata[31:0]));
    assign n_adiff = n_diff[32] ? 33'(-n_diff) : 33'(n_diff);
    assign n_tw    = (r_track == 24'd0) ? 24'd1 : r_track;

    assign s_tready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_track   <= TrackReset;
            r_offset  <= OffsetReset;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_step    <= '0;
            m_tvalid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CfgTrack:  r_track  <= i_cfg_data;
                    CfgOffset: r_offset <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready && r_state != S_DONE) m_tvalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == ReqClear) begin
                            r_pos_x   <= '0;
                            r_pos_y   <= '0;
                            r_heading <= '0;
                            r_sx      <= '0;
                            r_sy      <= '0;
                            r_state   <= S_DONE;
                        end else begin
                            r_dist  <= $signed(s_tdata[95:64]);
                            r_den   <= 34'(n_tw) * 34'(StepDiv);
                            r_rem   <= '0;
                            r_num   <= {n_adiff, 28'd0};
                            r_neg   <= n_diff[32];
                            r_cnt   <= '0;
                            r_phase <= 1'b0;
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_qbit ? 34'(n_trial - {1'b0, r_den}) : n_trial[33:0];
                    r_num <= {r_num[59:0], n_qbit};
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == 6'd60) r_state <= S_HEAD;
                end
                S_HEAD: begin
                    if (!r_phase) begin
                        r_step <= n_step;
                        r_ang  <= 34'(r_heading) + 34'((n_step + (n_step < 0 ? 1 : 0)) >>> 1);
                        r_mag  <= 34'(r_heading) + 34'((n_step + (n_step < 0 ? 1 : 0)) >>> 1);
                    end else begin
                        if (n_hsum > 33'sh0_7FFF_FFFF) r_heading <= 32'sh7FFF_FFFF;
                        else if (n_hsum < -33'sh0_8000_0000) r_heading <= 32'sh8000_0000;
                        else r_heading <= n_hsum[31:0];
                        r_ang <= 34'(n_hsum > 33'sh0_7FFF_FFFF ? 33'sh0_7FFF_FFFF :
                                    (n_hsum < -33'sh0_8000_0000 ? -33'sh0_8000_0000 : n_hsum));
                        r_mag <= 34'(n_hsum > 33'sh0_7FFF_FFFF ? 33'sh0_7FFF_FFFF :
                                    (n_hsum < -33'sh0_8000_0000 ? -33'sh0_8000_0000 : n_hsum));
                    end
                    r_state <= S_RED;
                end
                S_RED: begin
                    if (r_mag[33]) r_mag <= -r_mag;
                    else if ($signed(r_mag) >= Q28TwoPi) r_mag <= r_mag - Q28TwoPi;
                    else r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_x     <= CordicK;
                    r_y     <= '0;
                    r_z     <= n_fold <<< 2;
                    r_sel   <= n_flip;
                    r_cnt   <= '0;
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - (r_y >>> r_cnt[4:0]);
                        r_y <= r_y + (r_x >>> r_cnt[4:0]);
                        r_z <= r_z - atan_q30(r_cnt[4:0]);
                    end else begin
                        r_x <= r_x + (r_y >>> r_cnt[4:0]);
                        r_y <= r_y - (r_x >>> r_cnt[4:0]);
                        r_z <= r_z + atan_q30(r_cnt[4:0]);
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == IterLast) r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt != 6'd0) begin
                        r_sin <= r_y;
                        r_prod <= 66'(r_phase ? $signed({1'b0, r_offset}) : r_dist)
                                  * 66'(r_sel ? -r_x : r_x);
                        r_sel <= 1'b0;
                        r_cnt <= '0;
                    end else begin
                        r_prod <= 66'(r_phase ? $signed({1'b0, r_offset}) : r_dist)
                                  * 66'(r_sin);
                    end
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    if (!r_phase) begin
                        if (!r_sel) r_pos_x <= n_sat;
                        else r_pos_y <= n_sat;
                    end else begin
                        if (!r_sel) r_sx <= n_sat;
                        else r_sy <= n_sat;
                    end
                    if (!r_sel) begin
                        r_sel   <= 1'b1;
                        r_state <= S_MUL;
                    end else if (!r_phase) begin
                        r_phase <= 1'b1;
                        r_state <= S_HEAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!m_tvalid || m_tready) begin
                        m_tdata  <= {r_sy, r_sx, r_step, r_heading, r_pos_y, r_pos_x};
                        m_tvalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

### src/ddo_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the odometry block, bound to the top level.
// Depends on differential_drive_odometry.
module ddo_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [255:0] m_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && s_tready)
        else $error("bad state after reset");

endmodule

bind differential_drive_odometry ddo_checker u_ddo_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

### bench/tb_differential_drive_odometry.sv
`timescale 1ns / 1ps
// Self-checking bench for differential_drive_odometry: drives update and clear
// requests, predicts each pose result in-bench and compares. Depends on ddo_pkg and differential_drive_odometry.
module tb_differential_drive_odometry;
    import ddo_pkg::*;

    localparam int WatchLimit = 20000;
    localparam int HoldCycles = 3000;

    typedef struct {
        logic [47:0] px;
        logic [47:0] py;
        logic [31:0] hd;
        logic [31:0] st;
        logic [47:0] sx;
        logic [47:0] sy;
    } t_pose;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_addr = CfgTrack;
    logic [23:0]  i_cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;   // left_distance, right_distance, centre_distance
    logic         s_tuser = ReqUpdate;   // req_type
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [255:0] m_tdata;   // pose_x, pose_y, heading, heading_step, sensor_x, sensor_y

    differential_drive_odometry u_top (.*);

    always #4 i_clk = ~i_clk;

    t_pose pose_q[$];
    int    errors = 0;
    int    n_sent = 0;
    int    n_checked = 0;
    int    snd_idle = 0;
    int    rcv_stall = 0;
    int    hold_left = 0;
    bit    hold_go = 0;
    int    quiet = 0;

    // bench copy of block state and registers
    longint trk_w = TrackReset;
    longint sens_off = OffsetReset;
    longint px_r, py_r, hd_r, st_r;

    const longint atan_tab[32] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 7, 3, 1, 0, 0};

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic longint clamp48(longint v);
        return clamp(v, -(64'sd1 <<< 47), (64'sd1 <<< 47) - 1);
    endfunction

    function automatic longint clamp32(longint v);
        return clamp(v, -(64'sd1 <<< 31), (64'sd1 <<< 31) - 1);
    endfunction

    task automatic sincos(input longint ang, output longint c, output longint s);
        longint r, x, y, z, dx, dy;
        bit flip;
        r = ang % longint'(Q28TwoPi);
        x = longint'(CordicK);
        y = 0;
        flip = 0;
        if (r >= longint'(Q28Pi)) r -= longint'(Q28TwoPi);
        if (r < -longint'(Q28Pi)) r += longint'(Q28TwoPi);
        if (r > longint'(Q28HalfPi)) begin
            r = longint'(Q28Pi) - r;
            flip = 1;
        end else if (r < -longint'(Q28HalfPi)) begin
            r = -longint'(Q28Pi) - r;
            flip = 1;
        end
        z = r * 4;
        for (int i = 0; i < CordicIterDflt; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = y;
    endtask

    function automatic longint trig_scale(longint d, longint t);
        return (d * t + (64'sd1 <<< 29)) >>> 30;
    endfunction

    task automatic odometry_update(input logic req, input logic [95:0] dat, output t_pose p);
        longint l, r, d, tw, step, c, s, sx, sy;
        sx = 0;
        sy = 0;
        if (req == ReqClear) begin
            px_r = 0; py_r = 0; hd_r = 0;
        end else begin
            l = longint'(signed'(dat[31:0]));
            r = longint'(signed'(dat[63:32]));
            d = longint'(signed'(dat[95:64]));
            tw = (trk_w == 0) ? 1 : trk_w;
            step = clamp32(((r - l) * 268435456) / (1000 * tw));
            sincos(hd_r + step / 2, c, s);
            px_r = clamp48(px_r + trig_scale(d, c));
            py_r = clamp48(py_r + trig_scale(d, s));
            hd_r = clamp32(hd_r + step);
            st_r = step;
            sincos(hd_r, c, s);
            sx = clamp48(px_r + trig_scale(sens_off, c));
            sy = clamp48(py_r + trig_scale(sens_off, s));
        end
        p.px = px_r[47:0]; p.py = py_r[47:0];
        p.hd = hd_r[31:0]; p.st = st_r[31:0];
        p.sx = sx[47:0];   p.sy = sy[47:0];
    endtask

    task automatic report(input string what, input logic [47:0] got, input logic [47:0] want);
        errors++;
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_checked);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_pose e;
        if (m_tvalid && m_tready) begin
            if (pose_q.size() == 0) begin
                report("unexpected result", m_tdata[47:0], '0);
            end else begin
                e = pose_q.pop_front();
                if (m_tdata[47:0]    !== e.px) report("pose_x", m_tdata[47:0], e.px);
                if (m_tdata[95:48]   !== e.py) report("pose_y", m_tdata[95:48], e.py);
                if (m_tdata[127:96]  !== e.hd) report("heading", m_tdata[127:96], e.hd);
                if (m_tdata[159:128] !== e.st) report("heading_step", m_tdata[159:128], e.st);
                if (m_tdata[207:160] !== e.sx) report("sensor_x", m_tdata[207:160], e.sx);
                if (m_tdata[255:208] !== e.sy) report("sensor_y", m_tdata[255:208], e.sy);
            end
            n_checked++;
        end
    end

    // receiver ready, with long hold-off on request
    always @(negedge i_clk) begin
        if (hold_go) begin
            hold_left = HoldCycles;
            hold_go = 0;
        end
        if (hold_left > 0) begin
            m_tready = 1'b0;
            hold_left--;
        end else begin
            m_tready = ($urandom_range(99) >= rcv_stall);
        end
    end

    // watchdog on lack of progress
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !i_rst_n) quiet = 0;
        else quiet++;
        if (quiet >= WatchLimit) begin
            $display("timeout: no request moved for %0d cycles", WatchLimit);
            $display("FAIL differential_drive_odometry");
            $finish;
        end
    end

    task automatic send_req(input logic req, input logic [31:0] l, input logic [31:0] r,
                            input logic [31:0] d);
        t_pose p;
        @(negedge i_clk);
        while ($urandom_range(99) < snd_idle) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {d, r, l};
        do @(posedge i_clk); while (!s_tready);
        odometry_update(req, s_tdata, p);
        pose_q.push_back(p);
        n_sent++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_tvalid = 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (pose_q.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic addr, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_addr = addr;
        i_cfg_data = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        if (addr == CfgTrack) trk_w = val;
        else sens_off = val;
    endtask

    function automatic logic [31:0] rand_dist();
        if ($urandom_range(99) < 15) return $urandom;
        return 32'($signed($urandom_range(0, 131072)) - 65536);
    endfunction

    task automatic test_directed();
        write_cfg(CfgTrack, TrackReset);
        write_cfg(CfgOffset, 24'd65536);
        send_req(ReqUpdate, 32'd0, 32'd0, 32'd0);
        send_req(ReqUpdate, 32'd0, 32'd0, 32'h0001_0000);
        send_req(ReqUpdate, 32'h0000_1000, 32'h0000_3000, 32'h0000_8000);
        send_req(ReqUpdate, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        send_req(ReqUpdate, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_req(ReqUpdate, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_req(ReqClear, 32'hffff_ffff, 32'h1234_5678, 32'hffff_ffff);
        send_req(ReqClear, 32'd0, 32'd0, 32'd0);
        drain();
        write_cfg(CfgTrack, 24'd0);
        write_cfg(CfgOffset, 24'hff_ffff);
        send_req(ReqUpdate, 32'd0, 32'd1000, 32'h0001_0000);
        send_req(ReqUpdate, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
        repeat (4) send_req(ReqUpdate, 32'd0, 32'h0100_0000, 32'h7fff_ffff);
        send_req(ReqUpdate, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000);
        send_req(ReqClear, 32'd0, 32'd0, 32'd0);
        drain();
        write_cfg(CfgTrack, 24'hff_ffff);
        send_req(ReqUpdate, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        send_req(ReqUpdate, 32'h0000_0001, 32'h0000_0000, 32'h0000_0001);
        drain();
        write_cfg(CfgTrack, 24'd1);
        repeat (3) send_req(ReqUpdate, 32'd0, 32'h0002_0000, 32'h0001_0000);
        drain();
    endtask

    task automatic test_random(input int n, input int idle, input int stall,
                               input logic [23:0] tw, input logic [23:0] off);
        logic [31:0] l, r;
        write_cfg(CfgTrack, tw);
        write_cfg(CfgOffset, off);
        snd_idle = idle;
        rcv_stall = stall;
        for (int k = 0; k < n; k++) begin
            l = rand_dist();
            r = ($urandom_range(3) == 0) ? rand_dist() : l + 32'($urandom_range(0, 512)) - 256;
            send_req(($urandom_range(99) < 5) ? ReqClear : ReqUpdate, l, r, rand_dist());
        end
        drain();
        snd_idle = 0;
        rcv_stall = 0;
    endtask

    task automatic test_backpressure();
        snd_idle = 0;
        rcv_stall = 0;
        @(negedge i_clk);
        hold_go = 1;
        repeat (20) send_req(ReqUpdate, rand_dist(), rand_dist(), rand_dist());
        drain();
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        px_r = 0; py_r = 0; hd_r = 0; st_r = 0;
        test_directed();
        test_random(300, 0, 0, TrackReset, OffsetReset);
        test_random(300, 83, 0, 24'($urandom_range(1, 24'hff_ffff)), 24'($urandom));
        test_random(300, 0, 83, 24'($urandom_range(1, 20000)), 24'($urandom_range(0, 200000)));
        test_random(300, 19, 19, 24'd1, 24'hff_ffff);
        test_random(300, 19, 19, 24'hff_ffff, 24'd0);
        test_random(300, 0, 0, 24'd0, 24'd32768);
        test_backpressure();
        $display("covered %0d requests (updates and clears) over several track and offset",
                 n_sent);
        $display("settings and idle mixes, plus one long receiver hold; %0d results checked",
                 n_checked);
        if (errors == 0) begin
            $display("PASS differential_drive_odometry");
        end else begin
            $display("FAIL differential_drive_odometry");
        end
        $finish;
    end

endmodule
